>>> rtl/nearest_palette_color_index_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for nearest_palette_color_index_core
// Concurrent assertion wrappers, clocked, with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_INDEX_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_INDEX_CORE_ASSERT_SVH

// property checked outside reset
`define NPCI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define NPCI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/npci_pkg.sv
// ----------------------------------------------------------------------------
// npci_pkg
// Types and constants shared by the palette search core.
// ----------------------------------------------------------------------------
`default_nettype none

package npci_pkg;

   localparam int ChanWidth  = 8;
   localparam int IndexWidth = 8;
   localparam int SizeWidth  = 9;
   localparam int DistWidth  = 18;

   // word kinds on tuser
   localparam logic KindLoad  = 1'b0;
   localparam logic KindPixel = 1'b1;

   // index reported for an empty palette
   localparam logic [IndexWidth-1:0] EmptyIndex = 8'd255;

   typedef struct packed {
      logic [ChanWidth-1:0] alpha;
      logic [ChanWidth-1:0] blue;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] red;
   } color_type;

   // word traveling down the cell chain
   typedef struct packed {
      logic                  kind;
      logic [IndexWidth-1:0] entry_index;
      color_type             color;
      logic                  found;
      logic [IndexWidth-1:0] best_index;
      logic [DistWidth-1:0]  best_dist;
   } item_type;

   function automatic logic [2*ChanWidth-1:0] sq_diff(
      input logic [ChanWidth-1:0] a,
      input logic [ChanWidth-1:0] b
   );
      logic [ChanWidth-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d * d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/nearest_palette_color_index_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_index_core
// Nearest palette entry search for RGBA pixels over a chain of palette cells.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the result is stalled, which stalls the whole
// chain. Each palette entry lives in a cell of its own; every word walks the whole
// chain, two register stages per cell, and pixel results then pass the result
// register. Load words write their entry as they pass its cell, so loads and
// pixels keep stream order. The user must write palette_size through the csr port
// only while no word is in flight (not enforced). Zero gives index 255.
`default_nettype none

module nearest_palette_color_index_core #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // csr_data: palette_size[8:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata: entry_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32]
   input  wire logic [39:0] req_tdata,
   // req_tuser: kind[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: palette_index[7:0]
   output logic [7:0]       rsp_tdata
);

   logic [npci_pkg::SizeWidth-1:0] size_ff;
   logic                           advance;
   logic                           chain_valid [PALETTE_DEPTH+1];
   npci_pkg::item_type             chain_item  [PALETTE_DEPTH+1];
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_data_ff;

   // palette size register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_valid) begin
         size_ff <= csr_data;
      end
   end

   // whole chain moves unless the result is stuck
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // chain head
   always_comb begin
      chain_valid[0]                  = req_tvalid;
      chain_item[0].kind              = req_tuser;
      chain_item[0].entry_index       = req_tdata[7:0];
      chain_item[0].color.red         = req_tdata[15:8];
      chain_item[0].color.green       = req_tdata[23:16];
      chain_item[0].color.blue        = req_tdata[31:24];
      chain_item[0].color.alpha       = req_tdata[39:32];
      chain_item[0].found             = 1'b0;
      chain_item[0].best_index        = npci_pkg::EmptyIndex;
      chain_item[0].best_dist         = '0;
   end

   // one cell per entry
   for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
      npci_cell #(
         .INDEX (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .active    (size_ff > npci_pkg::SizeWidth'(k)),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   // result register, pixels only
   assign rsp_valid_in = chain_valid[PALETTE_DEPTH] &&
                         chain_item[PALETTE_DEPTH].kind == npci_pkg::KindPixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= chain_item[PALETTE_DEPTH].best_index;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/npci_cell.sv
// ----------------------------------------------------------------------------
// npci_cell
// One palette entry: holds the entry, computes the distance, keeps the best.
// ----------------------------------------------------------------------------
`default_nettype none

module npci_cell #(
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               active,
   input  wire logic               in_valid,
   input  wire npci_pkg::item_type in_item,
   output logic                    out_valid,
   output npci_pkg::item_type      out_item
);

   npci_pkg::color_type entry_ff;
   logic                a_valid_ff, b_valid_ff;
   npci_pkg::item_type  a_item_ff, b_item_ff;
   logic [npci_pkg::DistWidth-1:0] a_dist_ff, a_dist_in;
   npci_pkg::item_type  b_item_in;
   logic                hit;

   // load word reaching this cell writes the entry
   always_ff @(posedge clock) begin
      if (advance && in_valid && in_item.kind == npci_pkg::KindLoad &&
          in_item.entry_index == npci_pkg::IndexWidth'(INDEX)) begin
         entry_ff <= in_item.color;
      end
   end

   // stage a: distance to the held entry
   always_comb begin
      a_dist_in = npci_pkg::DistWidth'(npci_pkg::sq_diff(in_item.color.red,   entry_ff.red))
                + npci_pkg::DistWidth'(npci_pkg::sq_diff(in_item.color.green, entry_ff.green))
                + npci_pkg::DistWidth'(npci_pkg::sq_diff(in_item.color.blue,  entry_ff.blue))
                + npci_pkg::DistWidth'(npci_pkg::sq_diff(in_item.color.alpha, entry_ff.alpha));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff <= in_item;
         a_dist_ff <= a_dist_in;
      end
   end

   // stage b: keep the first strictly smaller distance
   always_comb begin
      hit       = active && (!a_item_ff.found || a_dist_ff < a_item_ff.best_dist);
      b_item_in = a_item_ff;
      if (hit) begin
         b_item_in.found      = 1'b1;
         b_item_in.best_dist  = a_dist_ff;
         b_item_in.best_index = npci_pkg::IndexWidth'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

`default_nettype wire

>>> rtl/npci_checker.sv
// ----------------------------------------------------------------------------
// npci_checker
// Port-level checks for the palette search core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_palette_color_index_core_assert.svh"

module npci_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata
);

   // a stalled result holds
   `NPCI_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")

   // a stalled result freezes the input side
   `NPCI_ASSERT(a_req_stall, clock, reset, rsp_tvalid && !rsp_tready |-> !req_tready, "input taken while output stalled")

   // no result right after reset
   `NPCI_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind nearest_palette_color_index_core npci_checker u_npci_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
